// ===== sv/drs_pkg.sv =====
// Package for the delimiter range splitter: result beat type, mode and
// request codes, queue sizing. No dependencies.
`default_nettype none

package drs_pkg;

  localparam int FIELD_W      = 16;
  localparam int POS_BITS_DEF = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [2:0] MODE_REMOVED    = 3'd0;
  localparam logic [2:0] MODE_ISOLATED   = 3'd1;
  localparam logic [2:0] MODE_MERGE_PREV = 3'd2;
  localparam logic [2:0] MODE_MERGE_NEXT = 3'd3;
  localparam logic [2:0] MODE_CONTIGUOUS = 3'd4;

  localparam logic REQ_MATCH = 1'b0;
  localparam logic REQ_END   = 1'b1;

  typedef struct packed {
    logic               plast;
    logic               pvalid;
    logic [FIELD_W-1:0] pend;
    logic [FIELD_W-1:0] pstart;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/delimiter_range_splitter.sv =====
// Delimiter range splitter top level: per-text piece cutting with a held
// piece, feeding the result queue. Depends on drs_pkg and drs_fifo.
//
//  channel  direction  payload
//  s_*      in         tuser req_type, tdata match_start/match_end/text_length
//  m_*      out        tdata piece_start/piece_end, tuser piece_valid,
//                      tlast last_of_text
//  cfg_*    in         cfg_data split_mode
//
// An accepted beat is worked in the same cycle and its 0..2 results are
// queued at the clock edge; the first can leave on the next cycle.
// The output port moves one result a cycle while m_tready is high.
// s_tready drops while the four-entry result queue has fewer than two
// free places. rst (synchronous) clears the mode, the text state and the
// queue; neither input channel is ready while it is high.
`default_nettype none

module delimiter_range_splitter
  import drs_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // match_start, match_end, text_length
  input  wire logic        s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // piece_start, piece_end
  output logic             m_tuser,  // piece_valid
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data  // split_mode
);

  localparam int PW = (POS_BITS < FIELD_W) ? POS_BITS : FIELD_W;

  logic [2:0]    split_mode;
  logic [PW-1:0] cursor, prev_match_start, held_start, held_end;
  logic          held_valid;

  logic [PW-1:0] ms, me, len;
  logic          accept, gap;

  // push A, held rewrite, push B, in that order
  logic          a_en, rw_en, b_en;
  logic [PW-1:0] a_s, a_e, rw_s, rw_e, b_s, b_e;

  logic [PW-1:0] hs, he;
  logic          hv;
  logic [1:0]    push_n;
  result_t       r0, r1, head;
  logic [QCNT_W-1:0] level;

  assign ms  = s_tdata[PW-1:0];
  assign me  = s_tdata[16+PW-1:16];
  assign len = s_tdata[32+PW-1:32];

  assign s_tready  = !rst && (level <= QCNT_W'(QDEPTH - 2));
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = !rst;

  always_comb begin
    a_en = 1'b0; a_s = cursor; a_e = ms;
    rw_en = 1'b0; rw_s = prev_match_start; rw_e = ms;
    b_en = 1'b0; b_s = ms; b_e = me;
    gap = (s_tuser == REQ_END) ? (len > cursor) : (ms > cursor);
    if (s_tuser == REQ_MATCH) begin
      case (split_mode)
        MODE_REMOVED: a_en = gap;
        MODE_ISOLATED: begin
          a_en = gap;
          b_en = 1'b1;
        end
        MODE_MERGE_PREV: begin
          b_en = 1'b1;
          if (gap) b_s = cursor;
        end
        MODE_MERGE_NEXT: begin
          a_en  = gap && !held_valid;
          rw_en = gap && held_valid;
          b_en  = 1'b1;
        end
        MODE_CONTIGUOUS: begin
          a_en = gap;
          if (ms == cursor && held_valid) begin
            rw_en = 1'b1;
            rw_s  = held_start;
            rw_e  = me;
          end else begin
            b_en = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      a_e  = len;
      rw_e = len;
      if (gap && split_mode <= MODE_CONTIGUOUS) begin
        if (split_mode == MODE_MERGE_NEXT && held_valid) rw_en = 1'b1;
        else a_en = 1'b1;
      end
    end
  end

  // Walk the held piece through the steps and collect what leaves
  always_comb begin
    hs = held_start; he = held_end; hv = held_valid;
    push_n = 2'd0;
    r0 = '0;
    r1 = '0;
    if (a_en) begin
      if (hv) begin
        r0 = '{plast: 1'b0, pvalid: 1'b1, pend: FIELD_W'(he), pstart: FIELD_W'(hs)};
        push_n = 2'd1;
      end
      hs = a_s; he = a_e; hv = 1'b1;
    end
    if (rw_en) begin
      hs = rw_s; he = rw_e;
    end
    if (b_en) begin
      if (hv) begin
        if (push_n == 2'd0)
          r0 = '{plast: 1'b0, pvalid: 1'b1, pend: FIELD_W'(he), pstart: FIELD_W'(hs)};
        else
          r1 = '{plast: 1'b0, pvalid: 1'b1, pend: FIELD_W'(he), pstart: FIELD_W'(hs)};
        push_n = 2'(push_n + 1'b1);
      end
      hs = b_s; he = b_e; hv = 1'b1;
    end
    if (s_tuser == REQ_END) begin
      // flush: held piece or the empty marker closes the text
      if (push_n == 2'd0)
        r0 = '{plast: 1'b1, pvalid: hv, pend: hv ? FIELD_W'(he) : '0,
               pstart: hv ? FIELD_W'(hs) : '0};
      else
        r1 = '{plast: 1'b1, pvalid: hv, pend: hv ? FIELD_W'(he) : '0,
               pstart: hv ? FIELD_W'(hs) : '0};
      push_n = 2'(push_n + 1'b1);
    end
    if (!accept) push_n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode       <= MODE_REMOVED;
      cursor           <= '0;
      prev_match_start <= '0;
      held_start       <= '0;
      held_end         <= '0;
      held_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) split_mode <= cfg_data;
      if (accept) begin
        if (s_tuser == REQ_END) begin
          cursor           <= '0;
          prev_match_start <= '0;
          held_start       <= '0;
          held_end         <= '0;
          held_valid       <= 1'b0;
        end else begin
          cursor           <= me;
          prev_match_start <= ms;
          held_start       <= hs;
          held_end         <= he;
          held_valid       <= hv;
        end
      end
    end
  end

  drs_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push0  (r0),
    .push1  (r1),
    .pop    (m_tvalid && m_tready),
    .head   (head),
    .level  (level)
  );

  assign m_tvalid = (level != '0);
  assign m_tdata  = {head.pend, head.pstart};
  assign m_tuser  = head.pvalid;
  assign m_tlast  = head.plast;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == REQ_END) |-> (push_n != 2'd0))
    else $error("end item queued no result");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == REQ_END) |=> (!held_valid && cursor == '0))
    else $error("text state not cleared after end item");

  a_last_only_on_end: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0 && (r0.plast || (push_n == 2'd2 && r1.plast)))
      |-> (s_tuser == REQ_END))
    else $error("last marked on a match item");

endmodule

`default_nettype wire

// ===== sv/drs_fifo.sv =====
// Result queue for the delimiter range splitter: takes up to two beats a
// cycle, gives one. Depends on drs_pkg.
`default_nettype none

module drs_fifo
  import drs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_n,
  input  wire result_t           push0,
  input  wire result_t           push1,
  input  wire logic              pop,
  output result_t                head,
  output logic [QCNT_W-1:0]      level
);

  result_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W-1:0]   wr_ptr1;
  logic [QCNT_W-1:0]   level_next;

  assign wr_ptr1 = QPTR_W'(wr_ptr + 1'b1);
  assign head    = mem[rd_ptr];

  always_comb begin
    level_next = level + QCNT_W'(push_n);
    if (pop) level_next = QCNT_W'(level_next - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (pop) rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      if (push_n == 2'd1) wr_ptr <= wr_ptr1;
      else if (push_n == 2'd2) wr_ptr <= QPTR_W'(wr_ptr + 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr]  <= push0;
    if (push_n == 2'd2) mem[wr_ptr1] <= push1;
  end

endmodule

`default_nettype wire

// ===== tb/tb_delimiter_range_splitter.sv =====
`timescale 1ns / 1ps
// Self-checking bench for delimiter_range_splitter. It streams match and
// end-of-text beats in, predicts the piece ranges per split mode and checks
// every result beat in order. Depends on drs_pkg and the block's RTL.
module tb_delimiter_range_splitter;
  import drs_pkg::*;

  // codes the block must treat as "no pieces"
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // match_start, match_end, text_length
  logic        s_tuser = 1'b0; // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // piece_start, piece_end
  logic        m_tuser;        // piece_valid
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;  // split_mode

  // predicted split state
  logic [2:0]  pr_mode   = MODE_REMOVED;
  logic [15:0] pr_cursor = '0;
  logic [15:0] pr_mstart = '0;
  logic [15:0] pr_hstart = '0;
  logic [15:0] pr_hend   = '0;
  logic        pr_hvalid = 1'b0;

  result_t due_pieces[$];
  result_t head_piece;

  int     errors = 0;
  int     items_sent = 0;
  int     texts_sent = 0;
  int     beats_checked = 0;
  int     phases_run = 0;
  longint cycles = 0;
  bit     calm = 1'b0;     // no idling on either side while set

  delimiter_range_splitter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped at cycle limit, %0d pieces outstanding", $time,
               due_pieces.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 9);

  function automatic void queue_piece(input logic [15:0] ps, input logic [15:0] pe,
                                      input logic pv, input logic pl);
    result_t r;
    r.pstart = ps;
    r.pend   = pe;
    r.pvalid = pv;
    r.plast  = pl;
    due_pieces.push_back(r);
  endfunction

  // new piece goes on hold, the previously held one is released
  function automatic void hold_piece(input logic [15:0] ps, input logic [15:0] pe);
    if (pr_hvalid) queue_piece(pr_hstart, pr_hend, 1'b1, 1'b0);
    pr_hstart = ps;
    pr_hend   = pe;
    pr_hvalid = 1'b1;
  endfunction

  function automatic void cut_pieces(input logic req, input logic [15:0] ms,
                                     input logic [15:0] me, input logic [15:0] len);
    logic gap;
    gap = ms > pr_cursor;
    if (req == REQ_MATCH) begin
      case (pr_mode)
        MODE_REMOVED: if (gap) hold_piece(pr_cursor, ms);
        MODE_ISOLATED: begin
          if (gap) hold_piece(pr_cursor, ms);
          hold_piece(ms, me);
        end
        MODE_MERGE_PREV: hold_piece(gap ? pr_cursor : ms, me);
        MODE_MERGE_NEXT: begin
          // the gap is folded into the held match piece
          if (gap && pr_hvalid) begin
            pr_hstart = pr_mstart;
            pr_hend   = ms;
          end else if (gap) begin
            hold_piece(pr_cursor, ms);
          end
          hold_piece(ms, me);
        end
        MODE_CONTIGUOUS: begin
          if (gap) hold_piece(pr_cursor, ms);
          if (ms == pr_cursor && pr_hvalid) pr_hend = me;
          else hold_piece(ms, me);
        end
        default: ;
      endcase
      pr_cursor = me;
      pr_mstart = ms;
    end else begin
      if (len > pr_cursor && pr_mode <= MODE_CONTIGUOUS) begin
        if (pr_mode == MODE_MERGE_NEXT && pr_hvalid) begin
          pr_hstart = pr_mstart;
          pr_hend   = len;
        end else begin
          hold_piece(pr_cursor, len);
        end
      end
      if (pr_hvalid) queue_piece(pr_hstart, pr_hend, 1'b1, 1'b1);
      else queue_piece('0, '0, 1'b0, 1'b1);
      pr_cursor = '0;
      pr_mstart = '0;
      pr_hstart = '0;
      pr_hend   = '0;
      pr_hvalid = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_pieces.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual start=%0d end=%0d valid=%0b last=%0b",
                 $time, m_tdata[15:0], m_tdata[31:16], m_tuser, m_tlast);
        errors++;
      end else begin
        head_piece = due_pieces.pop_front();
        beats_checked++;
        if (head_piece.pstart !== m_tdata[15:0] || head_piece.pend !== m_tdata[31:16] ||
            head_piece.pvalid !== m_tuser || head_piece.plast !== m_tlast) begin
          $display("%0t: mismatch: expected start=%0d end=%0d valid=%0b last=%0b", $time,
                   head_piece.pstart, head_piece.pend, head_piece.pvalid, head_piece.plast);
          $display("%0t:           actual   start=%0d end=%0d valid=%0b last=%0b", $time,
                   m_tdata[15:0], m_tdata[31:16], m_tuser, m_tlast);
          errors++;
        end
      end
    end
  end

  // called and returns at a falling edge; tvalid stays up for a following beat
  task automatic send_item(input logic req, input logic [15:0] ms, input logic [15:0] me,
                           input logic [15:0] len);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid = 1'b0;
      s_tuser  = 1'($urandom_range(1));
      s_tdata  = {16'($urandom), 32'($urandom)};
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {len, me, ms};
    do @(posedge clk); while (!s_tready);
    cut_pieces(req, ms, me, len);
    items_sent++;
    if (req == REQ_END) texts_sent++;
    @(negedge clk);
  endtask

  task automatic send_match(input logic [15:0] ms, input logic [15:0] me);
    send_item(REQ_MATCH, ms, me, 16'($urandom));
  endtask

  task automatic send_end(input logic [15:0] len);
    send_item(REQ_END, 16'($urandom), 16'($urandom), len);
  endtask

  // only written with the block drained; match beats may still be in flight
  task automatic write_mode(input logic [2:0] mode);
    s_tvalid = 1'b0;
    while (due_pieces.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = mode;
    do @(posedge clk); while (!cfg_ready);
    pr_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = 3'($urandom);
  endtask

  task automatic test_directed();
    logic [2:0] m;
    write_mode(MODE_REMOVED);
    send_end(16'd0);                       // empty text: marker only
    // gap, adjacent match, gap, tail to the top of the range
    for (m = MODE_REMOVED; m <= MODE_CONTIGUOUS; m++) begin
      write_mode(m);
      send_match(16'd3, 16'd5);
      send_match(16'd5, 16'd7);
      send_match(16'd9, 16'd12);
      send_end(16'hFFFF);
    end
    // reversed range, unordered match, length below cursor
    write_mode(MODE_MERGE_NEXT);
    send_match(16'd10, 16'd4);
    send_match(16'd2, 16'hFFFF);
    send_end(16'd0);
    write_mode(MODE_SPARE_HI);
    send_match(16'd1, 16'd2);
    send_end(16'd100);
  endtask

  task automatic send_text();
    int          n;
    logic [15:0] pos;
    logic [15:0] ms;
    logic [15:0] me;
    logic [15:0] len;
    n   = $urandom_range(0, 6);
    pos = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    repeat (n) begin
      if ($urandom_range(99) < 12) begin
        ms = 16'($urandom);
        me = 16'($urandom);
      end else begin
        ms = ($urandom_range(3) == 0) ? pos : pos + 16'($urandom_range(1, 20));
        me = ms + 16'($urandom_range(0, 8));
      end
      send_match(ms, me);
      pos = me;
    end
    case ($urandom_range(4))
      0: len = pos - 16'($urandom_range(1, 5));
      1: len = pos;
      2: len = 16'($urandom);
      default: len = pos + 16'($urandom_range(1, 30));
    endcase
    send_end(len);
  endtask

  task automatic test_random_texts(input int n_items, input logic [2:0] mode);
    int target;
    write_mode(mode);
    target = items_sent + n_items;
    while (items_sent < target) send_text();
    phases_run++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();

    calm = 1'b1;
    test_random_texts(200, MODE_ISOLATED);
    calm = 1'b0;
    test_random_texts(180, MODE_REMOVED);
    test_random_texts(180, MODE_ISOLATED);
    test_random_texts(180, MODE_MERGE_PREV);
    test_random_texts(180, MODE_MERGE_NEXT);
    test_random_texts(180, MODE_CONTIGUOUS);
    test_random_texts(100, 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
    repeat (5) test_random_texts(130, 3'($urandom_range(MODE_REMOVED, MODE_SPARE_HI)));

    s_tvalid = 1'b0;
    while (due_pieces.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d items in %0d texts over %0d random mode phases plus directed cases;",
             items_sent, texts_sent, phases_run);
    $display("%0d result beats compared, %0d errors.", beats_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
